[design/ednm_pkg.sv]
// ---------------------------------------------------------------------------
// ednm_pkg - shared types and constants for the edit-distance match unit
// Operation codes, field widths, saturation limit and the cell result type.
// ---------------------------------------------------------------------------
package ednm_pkg;

    localparam int unsigned MAX_LEN_DEFAULT = 64;

    localparam int unsigned CHAR_W = 8;
    localparam int unsigned DIST_W = 16;
    localparam int unsigned IDX_W  = 16;

    localparam logic [DIST_W-1:0] DIST_SAT = {DIST_W{1'b1}};
    localparam logic [IDX_W-1:0]  IDX_SAT  = {IDX_W{1'b1}};

    // Operation codes carried on the op field
    localparam logic [1:0] OP_SOURCE = 2'd0;
    localparam logic [1:0] OP_CAND   = 2'd1;
    localparam logic [1:0] OP_END    = 2'd2;
    localparam logic [1:0] OP_FINISH = 2'd3;

    // Result of one row cell update
    typedef struct packed {
        logic [DIST_W-1:0] value;
        logic              sat;
    } cell_res_t;

endpackage

[design/edit_distance_nearest_match_unit.sv]
// ---------------------------------------------------------------------------
// edit_distance_nearest_match_unit - nearest candidate by edit distance
// Loads a source string, then scores streamed candidates against it with a
// one-row Levenshtein update and reports the first closest candidate.
// ---------------------------------------------------------------------------
//
//  channel | handshake               | fields
//  --------+-------------------------+--------------------------------------
//  in      | in_valid / in_stall     | op, character, last
//  out     | out_valid / out_stall   | best_index, best_distance, found,
//          |                         | overflow
//
// Items: a source byte, an end-of-candidate item and a finish item are
// each handled as they are accepted. A candidate byte is accepted, then its
// row is updated one cell at a time, cells 0 to source_length, as set by
// the single cell update unit and the one read port of the distance row RAM.
// Reset: asynchronous, active low; control state clears at once, no sweep.
// The row RAM is never cleared: a fresh row reads its cell i as i.
// Stalls: the input stalls while a row update runs, and while a finished
// result waits in the output register with out_stall high.
// ---------------------------------------------------------------------------
module edit_distance_nearest_match_unit #(
    parameter int unsigned MAX_LEN = ednm_pkg::MAX_LEN_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        op,
    input  logic [ednm_pkg::CHAR_W-1:0]       character,
    input  logic                              last,

    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [ednm_pkg::IDX_W-1:0]        best_index,
    output logic [ednm_pkg::DIST_W-1:0]       best_distance,
    output logic                              found,
    output logic                              overflow
);

    localparam int unsigned ROW_DEPTH = MAX_LEN + 1;
    localparam int unsigned ROW_AW    = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;
    localparam int unsigned SRC_AW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam logic [ROW_AW-1:0] LEN_MAX = ROW_AW'(MAX_LEN);

    localparam int unsigned DW = ednm_pkg::DIST_W;
    localparam int unsigned IW = ednm_pkg::IDX_W;
    localparam int unsigned CW = ednm_pkg::CHAR_W;

    typedef enum logic {
        S_IDLE,
        S_ROW
    } state_t;

    // Control state
    state_t              state_reg,   state_next;
    logic [ROW_AW-1:0]   len_reg,     len_next;
    logic [ROW_AW-1:0]   cell_reg,    cell_next;
    logic [IW-1:0]       cnt_reg,     cnt_next;
    logic                fresh_reg,   fresh_next;
    logic [DW-1:0]       best_reg,    best_next;
    logic [IW-1:0]       pos_reg,     pos_next;
    logic                found_reg,   found_next;
    logic                ovf_reg,     ovf_next;
    logic                last_reg,    last_next;

    // Registered outputs
    logic                out_valid_reg,  out_valid_next;
    logic [IW-1:0]       out_index_reg,  out_index_next;
    logic [DW-1:0]       out_dist_reg,   out_dist_next;
    logic                out_found_reg,  out_found_next;
    logic                out_ovf_reg,    out_ovf_next;

    // Datapath payload
    logic [CW-1:0]       ch_reg,      ch_next;
    logic [DW-1:0]       left_reg,    left_next;
    logic [DW-1:0]       diag_reg,    diag_next;

    // Memories and the cell unit
    logic                src_we;
    logic [SRC_AW-1:0]   src_waddr;
    logic [SRC_AW-1:0]   src_raddr;
    logic [CW-1:0]       src_rdata;
    logic                row_we;
    logic [ROW_AW-1:0]   row_raddr;
    logic [DW-1:0]       row_rdata;
    logic [DW-1:0]       old_val;
    ednm_pkg::cell_res_t cell_res;

    // End-of-candidate bookkeeping
    logic                end_en;
    logic [DW-1:0]       end_d;

    logic                in_accept;
    logic                out_take;
    logic                row_last_cell;

    assign in_stall  = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign in_accept = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;

    assign out_valid     = out_valid_reg;
    assign best_index    = out_index_reg;
    assign best_distance = out_dist_reg;
    assign found         = out_found_reg;
    assign overflow      = out_ovf_reg;

    assign row_last_cell = (cell_reg == len_reg);

    // Read the next cell while the current one is written; read cell 0 when idle
    assign row_raddr = (state_reg == S_ROW && !row_last_cell) ?
                       cell_reg + 1'b1 : '0;
    assign src_raddr = cell_reg[SRC_AW-1:0];
    assign src_waddr = len_reg[SRC_AW-1:0];

    // A fresh row holds i at cell i without ever being written
    assign old_val = fresh_reg ? DW'(cell_reg) : row_rdata;

    ednm_ram #(
        .WIDTH (CW),
        .DEPTH (MAX_LEN)
    ) u_src_ram (
        .clk   (clk),
        .we    (src_we),
        .waddr (src_waddr),
        .wdata (character),
        .raddr (src_raddr),
        .rdata (src_rdata)
    );

    ednm_ram #(
        .WIDTH (DW),
        .DEPTH (ROW_DEPTH)
    ) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (cell_reg),
        .wdata (cell_res.value),
        .raddr (row_raddr),
        .rdata (row_rdata)
    );

    ednm_cell u_cell (
        .first    (cell_reg == '0),
        .match    (src_rdata == ch_reg),
        .old_val  (old_val),
        .left_val (left_reg),
        .diag_val (diag_reg),
        .res      (cell_res)
    );

    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        cell_next      = cell_reg;
        cnt_next       = cnt_reg;
        fresh_next     = fresh_reg;
        best_next      = best_reg;
        pos_next       = pos_reg;
        found_next     = found_reg;
        ovf_next       = ovf_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        out_index_next = out_index_reg;
        out_dist_next  = out_dist_reg;
        out_found_next = out_found_reg;
        out_ovf_next   = out_ovf_reg;
        ch_next        = ch_reg;
        left_next      = left_reg;
        diag_next      = diag_reg;
        src_we         = 1'b0;
        row_we         = 1'b0;
        end_en         = 1'b0;
        end_d          = '0;

        // drop the result once taken; a finish below may refill it
        if (out_take)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    case (op)
                        ednm_pkg::OP_SOURCE:
                        begin
                            // abandon any partial candidate, append or drop the byte
                            fresh_next = 1'b1;
                            if (len_reg < LEN_MAX)
                            begin
                                src_we   = 1'b1;
                                len_next = len_reg + 1'b1;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        ednm_pkg::OP_CAND:
                        begin
                            cell_next  = '0;
                            ch_next    = character;
                            last_next  = last;
                            state_next = S_ROW;
                        end
                        ednm_pkg::OP_END:
                        begin
                            end_en = 1'b1;
                            end_d  = fresh_reg ? DW'(len_reg) : left_reg;
                        end
                        ednm_pkg::OP_FINISH:
                        begin
                            out_valid_next = 1'b1;
                            out_index_next = found_reg ? pos_reg : '0;
                            out_dist_next  = found_reg ? best_reg : '0;
                            out_found_next = found_reg;
                            out_ovf_next   = ovf_reg;
                            len_next       = '0;
                            cnt_next       = '0;
                            fresh_next     = 1'b1;
                            best_next      = ednm_pkg::DIST_SAT;
                            pos_next       = '0;
                            found_next     = 1'b0;
                            ovf_next       = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_ROW:
            begin
                // update one cell, advance the left and diagonal neighbors
                row_we    = 1'b1;
                left_next = cell_res.value;
                diag_next = old_val;
                if (cell_res.sat)
                begin
                    ovf_next = 1'b1;
                end
                if (row_last_cell)
                begin
                    fresh_next = 1'b0;
                    state_next = S_IDLE;
                    if (last_reg)
                    begin
                        end_en = 1'b1;
                        end_d  = cell_res.value;
                    end
                end
                else
                begin
                    cell_next = cell_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Close a candidate: strict compare keeps the first at the minimum
        if (end_en)
        begin
            if (!found_reg || end_d < best_reg)
            begin
                best_next = end_d;
                pos_next  = cnt_reg;
            end
            found_next = 1'b1;
            if (cnt_reg == ednm_pkg::IDX_SAT)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
            fresh_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            cell_reg      <= '0;
            cnt_reg       <= '0;
            fresh_reg     <= 1'b1;
            best_reg      <= ednm_pkg::DIST_SAT;
            pos_reg       <= '0;
            found_reg     <= 1'b0;
            ovf_reg       <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_index_reg <= '0;
            out_dist_reg  <= '0;
            out_found_reg <= 1'b0;
            out_ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            cell_reg      <= cell_next;
            cnt_reg       <= cnt_next;
            fresh_reg     <= fresh_next;
            best_reg      <= best_next;
            pos_reg       <= pos_next;
            found_reg     <= found_next;
            ovf_reg       <= ovf_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
            out_index_reg <= out_index_next;
            out_dist_reg  <= out_dist_next;
            out_found_reg <= out_found_next;
            out_ovf_reg   <= out_ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg   <= ch_next;
        left_reg <= left_next;
        diag_reg <= diag_next;
    end

`ifndef SYNTHESIS
    // The row walk never passes the end of the source
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROW) |-> (cell_reg <= len_reg))
        else $error("row cell index beyond source length");

    // A finish clears the search and presents a result next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && op == ednm_pkg::OP_FINISH) |=>
        (out_valid && len_reg == '0 && !found_reg && fresh_reg))
        else $error("finish did not reset the search");

    // The best position never runs ahead of the candidate count
    assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> (pos_reg <= cnt_reg))
        else $error("best position ahead of candidate count");

    // A candidate byte holds the input off until its row is done
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && op == ednm_pkg::OP_CAND) |=> (state_reg == S_ROW && in_stall))
        else $error("candidate byte did not start a row update");
`endif

endmodule

[design/ednm_ram.sv]
// ---------------------------------------------------------------------------
// ednm_ram - generic simple dual-port RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module ednm_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[design/ednm_cell.sv]
// ---------------------------------------------------------------------------
// ednm_cell - Levenshtein row cell update
// Min of three neighbors plus one with saturation, or diagonal on a match; cell 0 is its old value plus one.
// ---------------------------------------------------------------------------
module ednm_cell (
    input  logic                              first,
    input  logic                              match,
    input  logic [ednm_pkg::DIST_W-1:0]       old_val,
    input  logic [ednm_pkg::DIST_W-1:0]       left_val,
    input  logic [ednm_pkg::DIST_W-1:0]       diag_val,
    output ednm_pkg::cell_res_t               res
);

    logic [ednm_pkg::DIST_W-1:0] min2;
    logic [ednm_pkg::DIST_W-1:0] min3;
    logic [ednm_pkg::DIST_W-1:0] base;

    always_comb
    begin
        min2 = (old_val < left_val) ? old_val : left_val;
        min3 = (diag_val < min2) ? diag_val : min2;
        base = first ? old_val : min3;

        if (!first && match)
        begin
            res.value = diag_val;
            res.sat   = 1'b0;
        end
        else if (base == ednm_pkg::DIST_SAT)
        begin
            // hold at the ceiling and flag it
            res.value = ednm_pkg::DIST_SAT;
            res.sat   = 1'b1;
        end
        else
        begin
            res.value = base + 1'b1;
            res.sat   = 1'b0;
        end
    end

endmodule

[tb/ednm_match_checker.sv]
// ---------------------------------------------------------------------------
// ednm_match_checker - scoreboard for the edit-distance nearest match unit
// Watches both channels, predicts each search answer with its own row-based
// edit-distance model and compares every result against the oldest one due.
// ---------------------------------------------------------------------------
module ednm_match_checker #(
    parameter int unsigned MAX_LEN = ednm_pkg::MAX_LEN_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [1:0]                    op,
    input  logic [ednm_pkg::CHAR_W-1:0]   character,
    input  logic                          last,

    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [ednm_pkg::IDX_W-1:0]    best_index,
    input  logic [ednm_pkg::DIST_W-1:0]   best_distance,
    input  logic                          found,
    input  logic                          overflow,

    output int                            fail_count,
    output int                            results_seen,
    output int                            pending
);

    localparam int unsigned CW = ednm_pkg::CHAR_W;
    localparam int unsigned DW = ednm_pkg::DIST_W;
    localparam int unsigned IW = ednm_pkg::IDX_W;

    typedef struct packed {
        logic [IW-1:0] idx;
        logic [DW-1:0] score;
        logic          hit;
        logic          ovf;
    } match_t;

    // search state of the predictor
    logic [CW-1:0] src_mem [0:MAX_LEN-1];
    logic [DW-1:0] lev_row [0:MAX_LEN];
    int            src_len;
    logic [IW-1:0] cand_cnt;
    logic [DW-1:0] best_dist;
    logic [IW-1:0] best_pos;
    logic          row_fresh;
    logic          any_cand;
    logic          ovf_seen;

    match_t match_due [$];

    function automatic void clear_search();
        src_len   = 0;
        cand_cnt  = '0;
        best_dist = ednm_pkg::DIST_SAT;
        best_pos  = '0;
        row_fresh = 1'b1;
        any_cand  = 1'b0;
        ovf_seen  = 1'b0;
    endfunction

    function automatic logic [DW-1:0] sat_bump(input logic [DW-1:0] v);
        if (v == ednm_pkg::DIST_SAT)
        begin
            ovf_seen = 1'b1;
            return ednm_pkg::DIST_SAT;
        end
        return v + 1'b1;
    endfunction

    // seed the row with 0..len the first time a candidate touches it
    function automatic void open_row();
        if (!row_fresh)
            return;
        for (int i = 0; i <= src_len; i++)
            lev_row[i] = DW'(i);
        row_fresh = 1'b0;
    endfunction

    function automatic void close_candidate();
        logic [DW-1:0] d;
        open_row();
        d = lev_row[src_len];
        if (!any_cand || d < best_dist)
        begin
            best_dist = d;
            best_pos  = cand_cnt;
        end
        any_cand = 1'b1;
        if (cand_cnt == ednm_pkg::IDX_SAT)
            ovf_seen = 1'b1;
        else
            cand_cnt = cand_cnt + 1'b1;
        row_fresh = 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        match_t        want;
        logic [DW-1:0] diag;
        logic [DW-1:0] saved;
        logic [DW-1:0] m;
        if (!rst_n)
        begin
            clear_search();
            match_due.delete();
        end
        else
        begin
            // check the result leaving the block on this edge
            if (out_valid && !out_stall)
            begin
                results_seen <= results_seen + 1;
                if (match_due.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("checker: unexpected result idx=%0d dist=%0d found=%0b ovf=%0b",
                                 best_index, best_distance, found, overflow);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = match_due.pop_front();
                    if (best_index !== want.idx || best_distance !== want.score ||
                        found !== want.hit || overflow !== want.ovf)
                    begin
                        if (fail_count < 10)
                            $display("checker: mismatch exp idx=%0d dist=%0d found=%0b ovf=%0b %s",
                                     want.idx, want.score, want.hit, want.ovf,
                                     $sformatf("got idx=%0d dist=%0d found=%0b ovf=%0b",
                                               best_index, best_distance, found, overflow));
                        fail_count <= fail_count + 1;
                    end
                end
            end

            // advance the model on the item entering the block
            if (in_valid && !in_stall)
            begin
                case (op)
                    ednm_pkg::OP_SOURCE:
                    begin
                        row_fresh = 1'b1;
                        if (src_len < MAX_LEN)
                        begin
                            src_mem[src_len] = character;
                            src_len++;
                        end
                        else
                            ovf_seen = 1'b1;
                    end
                    ednm_pkg::OP_CAND:
                    begin
                        open_row();
                        diag       = lev_row[0];
                        lev_row[0] = sat_bump(lev_row[0]);
                        for (int i = 1; i <= src_len; i++)
                        begin
                            saved = lev_row[i];
                            if (src_mem[i-1] == character)
                                lev_row[i] = diag;
                            else
                            begin
                                m = lev_row[i-1];
                                if (saved < m)
                                    m = saved;
                                if (diag < m)
                                    m = diag;
                                lev_row[i] = sat_bump(m);
                            end
                            diag = saved;
                        end
                        if (last)
                            close_candidate();
                    end
                    ednm_pkg::OP_END:
                        close_candidate();
                    ednm_pkg::OP_FINISH:
                    begin
                        want.idx   = any_cand ? best_pos : '0;
                        want.score = any_cand ? best_dist : '0;
                        want.hit   = any_cand;
                        want.ovf   = ovf_seen;
                        match_due  = {match_due, want};
                        clear_search();
                    end
                    default: ;
                endcase
            end
            pending <= match_due.size();
        end
    end

endmodule

[tb/tb.sv]
// ---------------------------------------------------------------------------
// tb - testbench top for edit_distance_nearest_match_unit
// Drives searches (source bytes, candidates, finish) with random idling on
// both channels, including over-long sources and a long output hold-off; a
// separate checker predicts and compares every answer.
// ---------------------------------------------------------------------------
module tb;

    localparam int unsigned MAX_LEN      = ednm_pkg::MAX_LEN_DEFAULT;
    localparam int unsigned CW           = ednm_pkg::CHAR_W;
    localparam int unsigned DW           = ednm_pkg::DIST_W;
    localparam int unsigned IW           = ednm_pkg::IDX_W;
    localparam int          RANDOM_ITEMS = 1500;
    // abort limit, with ample slack over the worst correct run
    localparam int          RUN_LIMIT    = 1000000;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;

    logic          in_valid = 1'b0;
    logic          in_stall;
    logic [1:0]    op = ednm_pkg::OP_SOURCE;
    logic [CW-1:0] character = '0;
    logic          last = 1'b0;

    logic          out_valid;
    logic          out_stall = 1'b0;
    logic [IW-1:0] best_index;
    logic [DW-1:0] best_distance;
    logic          found;
    logic          overflow;

    int            fail_count;
    int            results_seen;
    int            pending;

    int            items_sent;
    int            finishes_sent;
    int            searches_run;
    int            cycle_count;
    int            rx_hold_cycles;
    bit            tx_burst;

    // 20-unit clock period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    edit_distance_nearest_match_unit #(
        .MAX_LEN       (MAX_LEN)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .character     (character),
        .last          (last),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .best_index    (best_index),
        .best_distance (best_distance),
        .found         (found),
        .overflow      (overflow)
    );

    ednm_match_checker #(
        .MAX_LEN       (MAX_LEN)
    ) i_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .character     (character),
        .last          (last),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .best_index    (best_index),
        .best_distance (best_distance),
        .found         (found),
        .overflow      (overflow),
        .fail_count    (fail_count),
        .results_seen  (results_seen),
        .pending       (pending)
    );

    // Abort a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("run stopped at the cycle limit, %0d results outstanding",
                     finishes_sent - results_seen);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result side: draw a stall per result, sometimes run with no stall at all,
    // and honor a long hold-off request from the stimulus side.
    initial
    begin : rx_side
        int n;
        bit calm;
        calm = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (rx_hold_cycles > 0)
            begin
                n = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            else
                n = calm ? 0 : $urandom_range(0, 18);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            if ($urandom_range(0, 7) == 0)
                calm = !calm;
        end
    end

    function automatic logic [CW-1:0] draw_byte(input bit wide);
        if (wide)
            return CW'($urandom_range(0, 255));
        // narrow alphabet makes matches and ties likely
        return 8'h61 + CW'($urandom_range(0, 3));
    endfunction

    // Offer one item after a random gap and hold it until the block takes it.
    // Valid stays high on return so a back-to-back item never drops it.
    task automatic push_item(input logic [1:0] code, input logic [CW-1:0] ch,
                             input logic lst);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        op        <= code;
        character <= ch;
        last      <= lst;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
        if (code == ednm_pkg::OP_FINISH)
            finishes_sent++;
    endtask

    // Drop valid and hold off until every finished search has answered.
    task automatic drain_results();
        in_valid <= 1'b0;
        wait (results_seen >= finishes_sent);
        @(posedge clk);
    endtask

    // One search with random content: a source (now and then an over-long
    // one), a few candidates, mostly edited copies of the source, and a
    // finish. Occasionally break a candidate with a source byte or a finish.
    task automatic run_search();
        logic [CW-1:0] src [$];
        logic [CW-1:0] cand [$];
        int n_src;
        int n_cand;
        int len;
        int cut;
        int pos;
        bit wide;
        bit lengthy;
        bit noise;
        bit via_end;
        searches_run++;
        tx_burst = ($urandom_range(0, 5) == 0);
        wide     = ($urandom_range(0, 3) == 0);
        lengthy  = ($urandom_range(0, 15) == 0);
        n_src    = lengthy ? $urandom_range(MAX_LEN - 2, MAX_LEN + 3) : $urandom_range(0, 8);
        for (int k = 0; k < n_src; k++)
        begin
            src = {src, draw_byte(wide)};
            push_item(ednm_pkg::OP_SOURCE, src[k], 1'($urandom_range(0, 1)));
        end

        n_cand = $urandom_range(0, lengthy ? 2 : 6);
        for (int c = 0; c < n_cand; c++)
        begin
            cand.delete();
            if (lengthy || $urandom_range(0, 2) == 0)
            begin
                len = $urandom_range(0, lengthy ? 3 : 10);
                for (int j = 0; j < len; j++)
                    cand = {cand, draw_byte(wide)};
            end
            else
            begin
                cand = src;
                repeat ($urandom_range(0, 2))
                begin
                    pos = $urandom_range(0, cand.size());
                    case ($urandom_range(0, 2))
                        0: if (pos < cand.size()) cand[pos] = draw_byte(wide);
                        1: cand.insert(pos, draw_byte(wide));
                        default: if (pos < cand.size()) cand.delete(pos);
                    endcase
                end
            end

            len = cand.size();
            if (len == 0)
                push_item(ednm_pkg::OP_END, CW'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
            else
            begin
                noise   = ($urandom_range(0, 11) == 0);
                via_end = ($urandom_range(0, 3) == 0);
                cut     = noise ? $urandom_range(0, len - 1) : len;
                for (int j = 0; j < cut; j++)
                    push_item(ednm_pkg::OP_CAND, cand[j],
                              !noise && !via_end && j == len - 1);
                if (noise)
                begin
                    if ($urandom_range(0, 1) == 0)
                        push_item(ednm_pkg::OP_SOURCE, draw_byte(wide),
                                  1'($urandom_range(0, 1)));
                    else
                    begin
                        // finish with the candidate still open
                        push_item(ednm_pkg::OP_FINISH, CW'($urandom_range(0, 255)),
                                  1'($urandom_range(0, 1)));
                        return;
                    end
                end
                else if (via_end)
                    push_item(ednm_pkg::OP_END, CW'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
            end
        end
        push_item(ednm_pkg::OP_FINISH, CW'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    initial
    begin : stimulus
        int base;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed corners.
        // finish with nothing seen: empty answer
        push_item(ednm_pkg::OP_FINISH, 8'hFF, 1'b1);
        // source with extreme bytes; the first candidate is taken whatever its distance, the exact second one beats it
        push_item(ednm_pkg::OP_SOURCE, 8'h00, 1'b1);
        push_item(ednm_pkg::OP_SOURCE, 8'hFF, 1'b0);
        push_item(ednm_pkg::OP_SOURCE, 8'h61, 1'b0);
        push_item(ednm_pkg::OP_CAND, 8'hFF, 1'b0);
        push_item(ednm_pkg::OP_CAND, 8'h00, 1'b0);
        push_item(ednm_pkg::OP_CAND, 8'h61, 1'b1);
        push_item(ednm_pkg::OP_CAND, 8'h00, 1'b0);
        push_item(ednm_pkg::OP_CAND, 8'hFF, 1'b0);
        push_item(ednm_pkg::OP_CAND, 8'h61, 1'b1);
        // empty candidate, then a candidate closed by an end item
        push_item(ednm_pkg::OP_END, 8'hAA, 1'b1);
        push_item(ednm_pkg::OP_CAND, 8'h61, 1'b0);
        push_item(ednm_pkg::OP_END, 8'h55, 1'b0);
        push_item(ednm_pkg::OP_FINISH, 8'h00, 1'b0);
        // source byte in the middle of a candidate abandons it
        push_item(ednm_pkg::OP_SOURCE, 8'h6B, 1'b0);
        push_item(ednm_pkg::OP_CAND, 8'h6B, 1'b0);
        push_item(ednm_pkg::OP_SOURCE, 8'h7A, 1'b1);
        push_item(ednm_pkg::OP_CAND, 8'h6B, 1'b0);
        push_item(ednm_pkg::OP_CAND, 8'h7A, 1'b1);
        // finish drops the open candidate
        push_item(ednm_pkg::OP_CAND, 8'h71, 1'b0);
        push_item(ednm_pkg::OP_FINISH, 8'h5A, 1'b1);

        // Over-long source: drop the tail bytes and flag overflow.
        tx_burst = 1'b1;
        for (int k = 0; k < MAX_LEN + 2; k++)
            push_item(ednm_pkg::OP_SOURCE, CW'($urandom_range(0, 255)), 1'b0);
        push_item(ednm_pkg::OP_CAND, 8'h00, 1'b0);
        push_item(ednm_pkg::OP_CAND, 8'hFF, 1'b1);
        push_item(ednm_pkg::OP_FINISH, 8'h00, 1'b0);
        drain_results();

        // Back pressure: hold the result side off while searches keep coming,
        // so answers pile up and the input stalls; then pause until all are in.
        rx_hold_cycles = 400;
        for (int s = 0; s < 5; s++)
        begin
            push_item(ednm_pkg::OP_SOURCE, draw_byte(1'b0), 1'b0);
            push_item(ednm_pkg::OP_CAND, draw_byte(1'b0), 1'b1);
            push_item(ednm_pkg::OP_FINISH, 8'h00, 1'b0);
        end
        drain_results();
        tx_burst = 1'b0;

        // Random searches, with an occasional full drain between them.
        base = items_sent;
        while (items_sent - base < RANDOM_ITEMS)
        begin
            run_search();
            if (searches_run % 40 == 0)
                drain_results();
        end

        drain_results();
        repeat (MAX_LEN + 8) @(posedge clk);
        $display("sent %0d items in %0d random searches plus directed and back-pressure runs",
                 items_sent, searches_run);
        $display("checked %0d answers, %0d failures", results_seen, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
